// ===== src/mctt_pkg.sv =====
// Package for the multiplexed countdown timer table.
// Field widths, status and function codes, and the shared unit's result type.
// No dependencies.
package mctt_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int SLOT_W          = 4;
  localparam int STATUS_W        = 2;

  localparam logic FUNC_SET    = 1'b0;
  localparam logic FUNC_EXPIRE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_SET_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXPIRED    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_TIMER   = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] diff;   // saturating a - b
    logic              better; // diff beats the running minimum
  } alu_res_t;

endpackage

// ===== src/mctt_if.sv =====
// Channel interfaces for the timer table: set/expire items in, results out.
// Depends on mctt_pkg.
interface mctt_in_if;
  import mctt_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [DATA_W-1:0] duration;
  logic [DATA_W-1:0] unslept;

  modport source (output valid, output func, output duration, output unslept, input ready);
  modport sink   (input valid, input func, input duration, input unslept, output ready);
endinterface

interface mctt_out_if;
  import mctt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic                delay_valid;
  logic [DATA_W-1:0]   next_delay;

  modport source (output valid, output status, output slot, output delay_valid,
                  output next_delay, input ready);
  modport sink   (input valid, input status, input slot, input delay_valid,
                  input next_delay, output ready);
endinterface

// ===== src/mctt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mctt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== src/mctt_alu.sv =====
// Shared arithmetic unit: saturating subtract and compare against the running minimum.
// Depends on mctt_pkg.
module mctt_alu (
  input  logic [mctt_pkg::DATA_W-1:0] a,
  input  logic [mctt_pkg::DATA_W-1:0] b,
  input  logic [mctt_pkg::DATA_W-1:0] min_val,
  input  logic                        min_valid,
  output mctt_pkg::alu_res_t          res
);
  import mctt_pkg::*;

  logic [DATA_W-1:0] diff;

  always_comb begin
    diff       = (a > b) ? (a - b) : '0;
    res.diff   = diff;
    res.better = !min_valid || (diff < min_val);
  end
endmodule

// ===== src/multiplexed_countdown_timer_table_top.sv =====
// Top level of the multiplexed countdown timer table: sequencer, live bits, RAM, shared unit.
// Depends on mctt_pkg, mctt_if, mctt_ram and mctt_alu.
//
// A table of TIMER_SLOTS countdown timers shares one alarm. A set item places a timer in
// the lowest free slot after taking the elapsed time off every live timer; an expire item
// frees the earliest timer and takes its time off the others. Each result returns a status;
// a set or expire that is carried out also returns the slot and, when a timer is left, the
// next alarm delay. Remaining times live in a RAM with a registered read, and one
// subtract-and-compare unit walks the slots one per cycle; a full table or an expire with
// no timer running is answered from the idle state without a sweep. The input is not ready
// until the result has been taken.
module multiplexed_countdown_timer_table_top #(
  parameter int TIMER_SLOTS = mctt_pkg::TIMER_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  mctt_in_if.sink           in_ch,
  mctt_out_if.source        out_ch
);
  import mctt_pkg::*;

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_AMT   = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [TIMER_SLOTS-1:0] live_r, live_nxt;
  logic [IDX_W-1:0]       earliest_r, earliest_nxt;
  logic                   earliest_v_r, earliest_v_nxt;
  logic                   func_r, func_nxt;
  logic [DATA_W-1:0]      dur_r, dur_nxt;
  logic [DATA_W-1:0]      unslept_r, unslept_nxt;
  logic [IDX_W-1:0]       target_r, target_nxt;
  logic [DATA_W-1:0]      amount_r, amount_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   pend_r, pend_nxt;
  logic [IDX_W-1:0]       pend_idx_r, pend_idx_nxt;
  logic [DATA_W-1:0]      min_r, min_nxt;
  logic [IDX_W-1:0]       min_slot_r, min_slot_nxt;
  logic                   min_v_r, min_v_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic                   out_dv_r, out_dv_nxt;
  logic [DATA_W-1:0]      out_delay_r, out_delay_nxt;

  logic [IDX_W-1:0]       free_idx;
  logic                   full;
  logic                   in_acc;
  logic                   is_target;
  logic                   cand;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_raddr;
  logic [DATA_W-1:0]      ram_rdata;

  logic [DATA_W-1:0]      alu_a, alu_b;
  alu_res_t               alu_res;

  mctt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TIMER_SLOTS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pend_idx_r),
    .wdata (alu_res.diff),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mctt_alu u_alu (
    .a         (alu_a),
    .b         (alu_b),
    .min_val   (min_r),
    .min_valid (min_v_r),
    .res       (alu_res)
  );

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    full = &live_r;
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign in_acc           = in_ch.valid && (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.delay_valid = out_dv_r;
  assign out_ch.next_delay  = out_delay_r;

  assign is_target = (pend_idx_r == target_r);

  always_comb begin
    ram_raddr = (state_r == S_SWEEP) ? cnt_r[IDX_W-1:0] : earliest_r;

    // the new timer enters with its full duration; others lose the elapsed amount
    alu_a = ram_rdata;
    alu_b = amount_r;
    if (state_r == S_AMT) begin
      alu_b = (func_r == FUNC_SET) ? unslept_r : '0;
    end else if (func_r == FUNC_SET && is_target) begin
      alu_a = dur_r;
      alu_b = '0;
    end

    if (func_r == FUNC_SET) begin
      cand = is_target || live_r[pend_idx_r];
    end else begin
      cand = !is_target && live_r[pend_idx_r];
    end
    ram_we = (state_r == S_SWEEP) && pend_r && cand;
  end

  always_comb begin
    state_nxt      = state_r;
    live_nxt       = live_r;
    earliest_nxt   = earliest_r;
    earliest_v_nxt = earliest_v_r;
    func_nxt       = func_r;
    dur_nxt        = dur_r;
    unslept_nxt    = unslept_r;
    target_nxt     = target_r;
    amount_nxt     = amount_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    min_nxt        = min_r;
    min_slot_nxt   = min_slot_r;
    min_v_nxt      = min_v_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_dv_nxt     = out_dv_r;
    out_delay_nxt  = out_delay_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt    = in_ch.func;
          dur_nxt     = in_ch.duration;
          unslept_nxt = in_ch.unslept;
          amount_nxt  = '0;
          cnt_nxt     = '0;
          pend_nxt    = 1'b0;
          min_v_nxt   = 1'b0;
          if (in_ch.func == FUNC_SET) begin
            target_nxt = free_idx;
            if (full) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_TABLE_FULL;
              out_slot_nxt   = '0;
              out_dv_nxt     = 1'b0;
              out_delay_nxt  = '0;
              state_nxt      = S_DONE;
            end else if (earliest_v_r) begin
              state_nxt = S_AMT;
            end else begin
              state_nxt = S_SWEEP;
            end
          end else begin
            target_nxt = earliest_r;
            if (!earliest_v_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NO_TIMER;
              out_slot_nxt   = '0;
              out_dv_nxt     = 1'b0;
              out_delay_nxt  = '0;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_AMT;
            end
          end
        end
      end

      S_AMT: begin
        // elapsed time on set, earliest remaining time on expire
        amount_nxt = alu_res.diff;
        state_nxt  = S_SWEEP;
      end

      S_SWEEP: begin
        if (cnt_r < CNT_W'(TIMER_SLOTS)) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt      = cnt_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && cand && alu_res.better) begin
          min_nxt      = alu_res.diff;
          min_slot_nxt = pend_idx_r;
          min_v_nxt    = 1'b1;
        end
        if (pend_r && pend_idx_r == IDX_W'(TIMER_SLOTS - 1)) begin
          live_nxt[target_r] = (func_r == FUNC_SET);
          earliest_nxt       = min_v_nxt ? min_slot_nxt : '0;
          earliest_v_nxt     = min_v_nxt;
          out_valid_nxt      = 1'b1;
          out_status_nxt     = (func_r == FUNC_SET) ? ST_SET_OK : ST_EXPIRED;
          out_slot_nxt       = SLOT_W'(target_r);
          out_dv_nxt         = min_v_nxt;
          out_delay_nxt      = min_v_nxt ? min_nxt : '0;
          pend_nxt           = 1'b0;
          state_nxt          = S_DONE;
        end
      end

      S_DONE: begin
        // hold the result until taken
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      live_r       <= '0;
      earliest_r   <= '0;
      earliest_v_r <= 1'b0;
      pend_r       <= 1'b0;
      cnt_r        <= '0;
      min_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      live_r       <= live_nxt;
      earliest_r   <= earliest_nxt;
      earliest_v_r <= earliest_v_nxt;
      pend_r       <= pend_nxt;
      cnt_r        <= cnt_nxt;
      min_v_r      <= min_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    dur_r        <= dur_nxt;
    unslept_r    <= unslept_nxt;
    target_r     <= target_nxt;
    amount_r     <= amount_nxt;
    pend_idx_r   <= pend_idx_nxt;
    min_r        <= min_nxt;
    min_slot_r   <= min_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_dv_r     <= out_dv_nxt;
    out_delay_r  <= out_delay_nxt;
  end
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for multiplexed_countdown_timer_table_top: set/expire items against a
// timer-table predictor. Depends on mctt_pkg and the channel interfaces in mctt_if.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mctt_pkg::*;

  localparam int TIMER_SLOTS  = TIMER_SLOTS_DEF;
  localparam int N_DIRECTED   = 25;
  localparam int RANDOM_ITEMS = 1500;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                delay_valid;
    logic [DATA_W-1:0]   next_delay;
  } alarm_result_t;

  typedef struct packed {
    logic              func;
    logic [DATA_W-1:0] duration;
    logic [DATA_W-1:0] unslept;
    logic              fixed;  // want is typed in, not predicted
    alarm_result_t     want;
  } timer_cmd_t;

  logic clk = 1'b0;
  logic rst_n;

  mctt_in_if  in_ch();
  mctt_out_if out_ch();

  multiplexed_countdown_timer_table_top #(.TIMER_SLOTS(TIMER_SLOTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Timer table predictor state
  logic              timer_live [TIMER_SLOTS];
  logic [DATA_W-1:0] timer_left [TIMER_SLOTS];
  int                soonest_slot;
  logic              soonest_valid;

  alarm_result_t pending_alarms[$];
  int            mismatches;
  timer_cmd_t    directed_cmds [N_DIRECTED];

  function automatic void take_elapsed(input logic [DATA_W-1:0] amount);
    int i;
    for (i = 0; i < TIMER_SLOTS; i++) begin
      if (timer_live[i]) begin
        timer_left[i] = (timer_left[i] > amount) ? timer_left[i] - amount : '0;
      end
    end
  endfunction

  // Lowest index wins a tie
  function automatic void pick_soonest();
    int i;
    soonest_valid = 1'b0;
    soonest_slot  = 0;
    for (i = 0; i < TIMER_SLOTS; i++) begin
      if (timer_live[i] && (!soonest_valid || timer_left[i] < timer_left[soonest_slot])) begin
        soonest_slot  = i;
        soonest_valid = 1'b1;
      end
    end
  endfunction

  function automatic alarm_result_t predict_alarm(input logic func,
                                                  input logic [DATA_W-1:0] duration,
                                                  input logic [DATA_W-1:0] unslept);
    alarm_result_t r;
    int idx;
    int i;
    logic [DATA_W-1:0] cur;
    r = '0;
    if (func == FUNC_SET) begin
      idx = -1;
      for (i = TIMER_SLOTS - 1; i >= 0; i--) begin
        if (!timer_live[i]) idx = i;
      end
      if (idx < 0) begin
        r.status = ST_TABLE_FULL;
      end else begin
        if (soonest_valid) begin
          cur = timer_left[soonest_slot];
          take_elapsed((cur > unslept) ? cur - unslept : '0);
        end
        timer_live[idx] = 1'b1;
        timer_left[idx] = duration;
        pick_soonest();
        r.status      = ST_SET_OK;
        r.slot        = idx[SLOT_W-1:0];
        r.delay_valid = 1'b1;
        r.next_delay  = timer_left[soonest_slot];
      end
    end else if (!soonest_valid) begin
      r.status = ST_NO_TIMER;
    end else begin
      idx = soonest_slot;
      take_elapsed(timer_left[idx]);
      timer_live[idx] = 1'b0;
      timer_left[idx] = '0;
      pick_soonest();
      r.status = ST_EXPIRED;
      r.slot   = idx[SLOT_W-1:0];
      if (soonest_valid) begin
        r.delay_valid = 1'b1;
        r.next_delay  = timer_left[soonest_slot];
      end
    end
    return r;
  endfunction

  function automatic alarm_result_t res(input logic [STATUS_W-1:0] status,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic dv, input logic [DATA_W-1:0] delay);
    alarm_result_t r;
    r.status      = status;
    r.slot        = slot;
    r.delay_valid = dv;
    r.next_delay  = delay;
    return r;
  endfunction

  function automatic timer_cmd_t mk(input logic func, input logic [DATA_W-1:0] duration,
                                    input logic [DATA_W-1:0] unslept, input logic fixed,
                                    input alarm_result_t want);
    timer_cmd_t c;
    c.func     = func;
    c.duration = duration;
    c.unslept  = unslept;
    c.fixed    = fixed;
    c.want     = want;
    return c;
  endfunction

  // Mostly plausible unslept values, i.e. at or below the running alarm
  function automatic timer_cmd_t random_cmd(input int set_pct);
    timer_cmd_t c;
    int pick;
    logic [DATA_W-1:0] cur;
    c = '0;
    c.func = ($urandom_range(99, 0) < set_pct) ? FUNC_SET : FUNC_EXPIRE;
    pick = $urandom_range(99, 0);
    if (pick < 40)      c.duration = $urandom_range(64, 0);
    else if (pick < 70) c.duration = $urandom;
    else if (pick < 80) c.duration = '0;
    else if (pick < 90) c.duration = '1;
    else                c.duration = $urandom_range(1 << 20, 0);
    cur  = soonest_valid ? timer_left[soonest_slot] : '0;
    pick = $urandom_range(99, 0);
    if (pick < 60)      c.unslept = $urandom_range(cur, 0);
    else if (pick < 75) c.unslept = cur;
    else if (pick < 90) c.unslept = $urandom;
    else                c.unslept = cur + $urandom_range(1000, 1);
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Hold the item until taken, then predict it
  task automatic send_item(input timer_cmd_t c);
    alarm_result_t want;
    in_ch.valid    <= 1'b1;
    in_ch.func     <= c.func;
    in_ch.duration <= c.duration;
    in_ch.unslept  <= c.unslept;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = predict_alarm(c.func, c.duration, c.unslept);
    if (c.fixed) want = c.want;
    pending_alarms.push_back(want);
  endtask

  always @(posedge clk) begin : check_results
    alarm_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_alarms.size() == 0) begin
        report_mismatch("result with nothing pending", out_ch.next_delay, '0);
      end else begin
        want = pending_alarms.pop_front();
        if (out_ch.status != want.status)
          report_mismatch("status", DATA_W'(out_ch.status), DATA_W'(want.status));
        if (out_ch.slot != want.slot)
          report_mismatch("slot", DATA_W'(out_ch.slot), DATA_W'(want.slot));
        if (out_ch.delay_valid != want.delay_valid)
          report_mismatch("delay_valid", DATA_W'(out_ch.delay_valid),
                          DATA_W'(want.delay_valid));
        if (out_ch.next_delay != want.next_delay)
          report_mismatch("next_delay", out_ch.next_delay, want.next_delay);
      end
    end
  end

  // Receiver: random 16-bit ready patterns, some of them stall-free
  initial begin : result_sink
    logic [15:0] pattern;
    int j;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      pattern = ($urandom_range(3, 0) == 0) ? 16'hFFFF : 16'($urandom);
      for (j = 0; j < 16; j++) begin
        out_ch.ready <= pattern[j];
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    timer_cmd_t c;
    int k;
    int burst_left;
    int gap;
    int set_pct;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_SET;
    in_ch.duration = '0;
    in_ch.unslept  = '0;
    mismatches     = 0;
    for (k = 0; k < TIMER_SLOTS; k++) begin
      timer_live[k] = 1'b0;
      timer_left[k] = '0;
    end
    soonest_slot  = 0;
    soonest_valid = 1'b0;

    directed_cmds[0]  = mk(FUNC_EXPIRE, 32'd0, 32'd0, 1'b1, res(ST_NO_TIMER, 4'd0, 1'b0, 32'd0));
    directed_cmds[1]  = mk(FUNC_SET, '1, '1, 1'b1, res(ST_SET_OK, 4'd0, 1'b1, '1));
    directed_cmds[2]  = mk(FUNC_SET, 32'd0, 32'd0, 1'b0, '0);  // elapsed takes the whole max
    directed_cmds[3]  = mk(FUNC_EXPIRE, 32'd0, 32'd0, 1'b0, '0);
    directed_cmds[4]  = mk(FUNC_EXPIRE, 32'd0, 32'd0, 1'b0, '0);  // last timer leaves
    // Fill the table with a mix of elapsed cases
    directed_cmds[5]  = mk(FUNC_SET, 32'd1000, 32'd0, 1'b0, '0);
    directed_cmds[6]  = mk(FUNC_SET, 32'd500, 32'd1000, 1'b0, '0);
    directed_cmds[7]  = mk(FUNC_SET, 32'd700, 32'd400, 1'b0, '0);
    directed_cmds[8]  = mk(FUNC_SET, '1, '1, 1'b0, '0);
    directed_cmds[9]  = mk(FUNC_SET, 32'd1, 32'd0, 1'b0, '0);
    directed_cmds[10] = mk(FUNC_SET, 32'd0, 32'd0, 1'b0, '0);
    directed_cmds[11] = mk(FUNC_SET, 32'd0, 32'd1, 1'b0, '0);
    directed_cmds[12] = mk(FUNC_SET, 32'h8000_0000, 32'd5, 1'b0, '0);
    directed_cmds[13] = mk(FUNC_SET, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0);
    directed_cmds[14] = mk(FUNC_SET, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0);
    directed_cmds[15] = mk(FUNC_SET, 32'd10, 32'd0, 1'b0, '0);
    directed_cmds[16] = mk(FUNC_SET, 32'd10, 32'd0, 1'b0, '0);
    directed_cmds[17] = mk(FUNC_SET, 32'd20, 32'd3, 1'b0, '0);
    directed_cmds[18] = mk(FUNC_SET, 32'd7, 32'd7, 1'b0, '0);
    directed_cmds[19] = mk(FUNC_SET, 32'd123456, 32'd0, 1'b0, '0);
    directed_cmds[20] = mk(FUNC_SET, 32'd42, 32'd42, 1'b0, '0);
    directed_cmds[21] = mk(FUNC_SET, 32'd99, 32'd0, 1'b1, res(ST_TABLE_FULL, 4'd0, 1'b0, 32'd0));
    directed_cmds[22] = mk(FUNC_EXPIRE, 32'd0, 32'd0, 1'b0, '0);
    directed_cmds[23] = mk(FUNC_EXPIRE, 32'd0, 32'd0, 1'b0, '0);
    directed_cmds[24] = mk(FUNC_EXPIRE, 32'd0, 32'd0, 1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = $urandom_range(40, 1);
    set_pct    = 50;
    for (k = 0; k < N_DIRECTED + RANDOM_ITEMS; k++) begin
      if (k == N_DIRECTED || (k > N_DIRECTED && k % 400 == 0)) begin
        // Let the table settle with nothing in flight
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_alarms.size() != 0) @(posedge clk);
      end else if (burst_left == 0) begin
        gap = $urandom_range(8, 0);
        if (gap > 0 && $urandom_range(2, 0) != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(40, 1);
      end
      if (k >= N_DIRECTED && (k - N_DIRECTED) % 64 == 0) begin
        case ($urandom_range(3, 0))
          0:       set_pct = 20;
          1:       set_pct = 50;
          2:       set_pct = 80;
          default: set_pct = 95;
        endcase
      end
      c = (k < N_DIRECTED) ? directed_cmds[k] : random_cmd(set_pct);
      send_item(c);
      burst_left--;
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_alarms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/mctt_pkg.sv
src/mctt_if.sv
src/mctt_ram.sv
src/mctt_alu.sv
src/multiplexed_countdown_timer_table_top.sv
tb/sv/tb.sv
